FILE: sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the stream hash block.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int NUM_ROUNDS = 64;
    localparam int NUM_WORDS  = 16;
    localparam int NUM_CHAIN  = 8;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    // Datapath commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUT,
        CMD_PAD,
        CMD_START,
        CMD_ROUND,
        CMD_FOLD,
        CMD_CLEAR,
        CMD_LEN
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic       count;
        logic [7:0] value;
        logic [5:0] round;
        logic       reinit;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
    } dp_stat_t;

    function automatic word_t ror(input word_t x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t initial_hash(input logic [2:0] i);
        case (i)
            3'd0:    initial_hash = 32'h6a09e667;
            3'd1:    initial_hash = 32'hbb67ae85;
            3'd2:    initial_hash = 32'h3c6ef372;
            3'd3:    initial_hash = 32'ha54ff53a;
            3'd4:    initial_hash = 32'h510e527f;
            3'd5:    initial_hash = 32'h9b05688c;
            3'd6:    initial_hash = 32'h1f83d9ab;
            default: initial_hash = 32'h5be0cd19;
        endcase
    endfunction

    localparam word_t ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

FILE: sv/sha256_stream_hash.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Hashes a byte stream and returns the digest as eight 32-bit words.
//
//   channel | handshake        | payload
//   --------+------------------+-------------------------------------
//   input   | in_valid/ready   | data_byte, byte_valid, msg_last
//   output  | out_valid/ready  | digest_word, word_index, word_last
//
// Each byte is written into the block buffer; the 64th byte of a block starts
// a compression (one round per cycle in the shared round unit). The last item
// adds padding and one or two compressions, then eight output beats. Input is
// held off during compression and output.
// Reset loads the initial hash values and clears counts; no clearing pass.
// ----------------------------------------------------------------------------
module sha256_stream_hash
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        msg_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        word_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    word_t    chain [NUM_CHAIN];

    sha256_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .msg_last   (msg_last),
        .stat       (stat),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_index (word_index)
    );

    sha256_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .chain (chain)
    );

    assign digest_word = chain[word_index];
    assign word_last   = (word_index == 3'd7);

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input open while digest pending");

    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_index == 3'd0))
        else $error("digest does not start at word 0");

    a_end_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && word_last) |=> (in_ready && !out_valid))
        else $error("block not idle after last word");
`endif

endmodule

FILE: sv/sha256_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, round registers, chaining words, bit count.
// ----------------------------------------------------------------------------
module sha256_dp
    import sha256_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output word_t    chain [NUM_CHAIN]
);

    word_t       w_reg [NUM_WORDS];
    word_t       v_reg [NUM_CHAIN];
    word_t       h_reg [NUM_CHAIN];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;

    logic [3:0]  wi;
    logic [1:0]  bk;
    word_t       cur;
    word_t       put_word;
    word_t       s0;
    word_t       s1;
    word_t       w_new;
    word_t       big0;
    word_t       big1;
    word_t       ch;
    word_t       maj;
    word_t       t1;
    word_t       t2;

    assign wi = fill_reg[5:2];
    assign bk = fill_reg[1:0];
    assign cur = w_reg[wi];

    always_comb
    begin
        case (bk)
            2'd0:    put_word = {cmd.value, 24'h0};
            2'd1:    put_word = {cur[31:24], cmd.value, 16'h0};
            2'd2:    put_word = {cur[31:16], cmd.value, 8'h0};
            default: put_word = {cur[31:8], cmd.value};
        endcase
        s0    = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        big1  = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + ROUND_K[cmd.round] + w_reg[0];
        big0  = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = big0 + maj;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_PUT, CMD_PAD:
            begin
                w_reg[wi] <= put_word;
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    if (cmd.op == CMD_PAD && i > int'(wi))
                    begin
                        w_reg[i] <= '0;
                    end
                end
            end
            CMD_START:
            begin
                for (int i = 0; i < NUM_CHAIN; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            CMD_ROUND:
            begin
                for (int i = 0; i < NUM_WORDS - 1; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[NUM_WORDS - 1] <= w_new;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < NUM_WORDS - 2; i++)
                begin
                    w_reg[i] <= '0;
                end
                w_reg[14] <= bits_reg[63:32];
                w_reg[15] <= bits_reg[31:0];
            end
            CMD_LEN:
            begin
                w_reg[14] <= bits_reg[63:32];
                w_reg[15] <= bits_reg[31:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bits_reg <= '0;
            for (int i = 0; i < NUM_CHAIN; i++)
            begin
                h_reg[i] <= initial_hash(3'(i));
            end
        end
        else
        begin
            if (cmd.count)
            begin
                fill_reg <= fill_reg + 6'd1;
                bits_reg <= bits_reg + 64'd8;
            end
            if (cmd.op == CMD_FOLD)
            begin
                for (int i = 0; i < NUM_CHAIN; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (cmd.reinit)
            begin
                fill_reg <= '0;
                bits_reg <= '0;
                for (int i = 0; i < NUM_CHAIN; i++)
                begin
                    h_reg[i] <= initial_hash(3'(i));
                end
            end
        end
    end

    assign stat.fill = fill_reg;
    assign chain     = h_reg;

endmodule

FILE: sv/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       msg_last,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] word_index
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_START,
        S_ROUND,
        S_FOLD,
        S_LEN,
        S_OUT
    } state_t;

    // Phase of the compression: data block, extra pad block, final block.
    typedef enum logic [1:0] {
        PH_DATA,
        PH_EXTRA,
        PH_FINAL
    } phase_t;

    state_t     state_reg;
    phase_t     phase_reg;
    logic       last_reg;
    logic [5:0] round_reg;
    logic [2:0] idx_reg;
    logic       ovalid_reg;

    logic       acc;
    logic       full;

    assign in_ready   = (state_reg == S_IDLE);
    assign acc        = in_valid && in_ready;
    assign full       = (stat.fill == 6'd63);
    assign out_valid  = ovalid_reg;
    assign word_index = idx_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.op     = CMD_NONE;
        cmd.value  = PAD_BYTE;
        cmd.round  = round_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc && byte_valid)
                begin
                    cmd.op    = CMD_PUT;
                    cmd.value = data_byte;
                    cmd.count = 1'b1;
                end
            end
            S_PAD:   cmd.op = CMD_PAD;
            S_START: cmd.op = CMD_START;
            S_ROUND: cmd.op = CMD_ROUND;
            S_FOLD:  cmd.op = CMD_FOLD;
            S_LEN:   cmd.op = (phase_reg == PH_EXTRA) ? CMD_CLEAR : CMD_LEN;
            S_OUT:   cmd.reinit = out_ready && (idx_reg == 3'd7);
            default: cmd.op = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_DATA;
            last_reg   <= 1'b0;
            round_reg  <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        last_reg <= msg_last;
                        if (byte_valid && full)
                        begin
                            phase_reg <= PH_DATA;
                            state_reg <= S_START;
                        end
                        else if (msg_last)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    if (stat.fill >= 6'd56)
                    begin
                        phase_reg <= PH_EXTRA;
                        state_reg <= S_START;
                    end
                    else
                    begin
                        phase_reg <= PH_FINAL;
                        state_reg <= S_LEN;
                    end
                end
                S_LEN:
                begin
                    if (phase_reg == PH_EXTRA)
                    begin
                        phase_reg <= PH_FINAL;
                    end
                    state_reg <= S_START;
                end
                S_START:
                begin
                    round_reg <= '0;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(NUM_ROUNDS - 1))
                    begin
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD:
                begin
                    case (phase_reg)
                        PH_DATA:  state_reg <= last_reg ? S_PAD : S_IDLE;
                        PH_EXTRA: state_reg <= S_LEN;
                        default:
                        begin
                            idx_reg    <= '0;
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            ovalid_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: tb/tb_sha256_stream_hash.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash testbench
// Streams messages of directed and random lengths into the hash block at most
// one byte per beat, predicts each digest with a local SHA-256 model and checks
// every digest word beat in order. Sender and receiver idle at random; one
// long receiver hold-off lets the block fill up and stall its input.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hash
    import sha256_pkg::*;
();

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  HOLD_OFF_CYCLES = 600;

    typedef struct packed {
        logic [7:0] data;
        logic       bvalid;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        msg_last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        word_last;

    beat_t        pending_beats[$];
    digest_beat_t expected_digest[$];

    word_t       chain[8];
    word_t       blk[16];
    logic [5:0]  fill;
    logic [63:0] bit_count;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  hold_cnt;
    int  quiet_cycles;
    int  errors;
    int  beats_sent;
    int  digests_seen;
    int  messages;

    sha256_stream_hash DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .byte_valid(byte_valid), .msg_last(msg_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .word_last(word_last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic init_chain();
        for (int i = 0; i < 8; i++)
            chain[i] = ROUND_K[0] ^ ROUND_K[0];
        chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
        chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
        chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
        chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
        fill = '0;
        bit_count = '0;
    endtask

    task automatic compress();
        word_t w[64];
        word_t v[8];
        word_t s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = blk[t];
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int t = 0; t < 8; t++)
            v[t] = chain[t];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
            chain[t] += v[t];
    endtask

    task automatic place_byte(logic [5:0] pos, logic [7:0] b);
        int wi;
        int sh;
        wi = pos[5:2];
        sh = 24 - 8 * pos[1:0];
        if (pos[1:0] == 2'd0)
            blk[wi] = {b, 24'h0};
        else
            blk[wi] = (blk[wi] & (32'hFFFFFFFF << (sh + 8))) | (word_t'(b) << sh);
    endtask

    task automatic hash_beat(beat_t it);
        if (it.bvalid)
        begin
            place_byte(fill, it.data);
            bit_count += 64'd8;
            fill = fill + 6'd1;
            if (fill == 6'd0)
                compress();
        end
        if (it.last)
        begin
            place_byte(fill, PAD_BYTE);
            for (int w = fill[5:2] + 1; w < 16; w++)
                blk[w] = '0;
            if (fill >= 6'd56)
            begin
                compress();
                for (int w = 0; w < 14; w++)
                    blk[w] = '0;
            end
            blk[14] = bit_count[63:32];
            blk[15] = bit_count[31:0];
            compress();
            for (int i = 0; i < 8; i++)
                expected_digest.push_back('{chain[i], 3'(i), i == 7});
            init_chain();
        end
    endtask

    task automatic add_message(int len, bit empty_end, bit extremes);
        beat_t it;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                pending_beats.push_back('{8'($urandom), 1'b0, 1'b0});
            it.data = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
            it.bvalid = 1'b1;
            it.last = !empty_end && (i == len - 1);
            pending_beats.push_back(it);
        end
        if (empty_end || len == 0)
            pending_beats.push_back('{8'($urandom), 1'b0, 1'b1});
        messages++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= '0;
            byte_valid <= 1'b0;
            msg_last   <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                hash_beat('{data_byte, byte_valid, msg_last});
                beats_sent++;
            end
            if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid   <= 1'b1;
                data_byte  <= pending_beats[0].data;
                byte_valid <= pending_beats[0].bvalid;
                msg_last   <= pending_beats[0].last;
                void'(pending_beats.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                digests_seen++;
                if (expected_digest.size() == 0)
                begin
                    $display("%0t: unexpected digest beat word=%h index=%0d last=%b",
                             $time, digest_word, word_index, word_last);
                    errors++;
                end
                else
                begin
                    if (expected_digest[0].word !== digest_word)
                    begin
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 expected_digest[0].word, digest_word);
                        errors++;
                    end
                    if (expected_digest[0].index !== word_index)
                    begin
                        $display("%0t: word_index expected %0d actual %0d", $time,
                                 expected_digest[0].index, word_index);
                        errors++;
                    end
                    if (expected_digest[0].last !== word_last)
                    begin
                        $display("%0t: word_last expected %b actual %b", $time,
                                 expected_digest[0].last, word_last);
                        errors++;
                    end
                    void'(expected_digest.pop_front());
                end
            end
            if (hold_off)
            begin
                out_ready <= 1'b0;
                hold_cnt  <= hold_cnt + 1;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (hold_cnt >= HOLD_OFF_CYCLES)
            hold_off <= 1'b0;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_valid || expected_digest.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        errors = 0; beats_sent = 0; digests_seen = 0; messages = 0;
        quiet_cycles = 0; hold_off = 1'b0;
        send_idle_pct = 7; recv_idle_pct = 65;
        init_chain();
        for (int i = 0; i < 16; i++)
            blk[i] = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, one byte, extremes, block boundaries
        add_message(0, 1'b1, 1'b0);
        add_message(1, 1'b0, 1'b1);
        add_message(3, 1'b1, 1'b1);
        add_message(2, 1'b0, 1'b1);
        add_message(2, 1'b0, 1'b0);
        add_message(1, 1'b1, 1'b0);
        wait_drained();

        add_message(55, 1'b0, 1'b0);
        add_message(56, 1'b0, 1'b1);
        add_message(64, 1'b0, 1'b0);
        // hold the receiver while the sender keeps offering
        hold_off = 1'b1;
        hold_cnt = 0;
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 7 : 0;
            for (int m = 0; m < 8; m++)
                add_message($urandom_range(0, 8), $urandom_range(0, 4) == 0, 1'b0);
            wait_drained();
        end
        repeat (200) @(posedge clk);

        $display("Sent %0d input beats in %0d messages; checked %0d digest words.",
                 beats_sent, messages, digests_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
